// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/vps_pkg.sv =====
package vps_pkg;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_TICK   = 3'd0;
   localparam kind_type KIND_OPEN   = 3'd1;
   localparam kind_type KIND_CLOSE  = 3'd2;
   localparam kind_type KIND_DETECT = 3'd3;
   localparam kind_type KIND_SAMPLE = 3'd4;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_OPEN_DELAY    = 2'd0;
   localparam csr_index_type CSR_ARM_DELAY     = 2'd1;
   localparam csr_index_type CSR_DARK_THRESH   = 2'd2;
   localparam csr_index_type CSR_TRIGGER_WIDTH = 2'd3;

   localparam logic [31:0] OPEN_DELAY_RESET    = 32'd0;
   localparam logic [31:0] ARM_DELAY_RESET     = 32'd10000;
   localparam logic [12:0] DARK_THRESH_RESET   = 13'd609;
   localparam logic [31:0] TRIGGER_WIDTH_RESET = 32'd10000;

   typedef struct packed {
      logic [31:0] open_delay_us;
      logic [31:0] arm_delay_us;
      logic [12:0] dark_threshold;
      logic [31:0] trigger_width_us;
   } cfg_type;

   // Request as held in the input register, duration already in microseconds.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] duration_us;
      logic [11:0] sample;
   } req_type;

   typedef struct packed {
      logic valve_on;
      logic trigger_on;
      logic laser_on;
      logic waiting_open;
      logic droplet_hit;
   } result_type;

   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == MAX32) ? v : v + 32'd1;
   endfunction

   // 1000 = 1024 - 16 - 8; saturates at the top of the 32-bit range.
   function automatic logic [31:0] ms_to_us(input logic [22:0] ms);
      logic [32:0] wide;
      wide = ({10'd0, ms} << 10) - ({10'd0, ms} << 4) - ({10'd0, ms} << 3);
      ms_to_us = wide[32] ? MAX32 : wide[31:0];
   endfunction

endpackage

// ===== rtl/vps_cfg_regs.sv =====
module vps_cfg_regs import vps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OPEN_DELAY:    cfg_in.open_delay_us    = csr_wdata;
            CSR_ARM_DELAY:     cfg_in.arm_delay_us     = csr_wdata;
            CSR_DARK_THRESH:   cfg_in.dark_threshold   = csr_wdata[12:0];
            CSR_TRIGGER_WIDTH: cfg_in.trigger_width_us = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_delay_us    <= OPEN_DELAY_RESET;
         cfg_ff.arm_delay_us     <= ARM_DELAY_RESET;
         cfg_ff.dark_threshold   <= DARK_THRESH_RESET;
         cfg_ff.trigger_width_us <= TRIGGER_WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/vps_core.sv =====
module vps_core import vps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  req_type    req,
   input  cfg_type    cfg,
   output result_type res
);

   logic        valve_ff, valve_in;
   logic        trig_ff, trig_in;
   logic        detect_ff, detect_in;
   logic        drop_pend_ff, drop_pend_in;
   logic        cmd_pend_ff, cmd_pend_in;
   logic [31:0] open_time_ff, open_time_in;
   logic [31:0] since_open_ff, since_open_in;
   logic [31:0] since_laser_ff, since_laser_in;
   logic [31:0] since_drop_ff, since_drop_in;
   logic [31:0] since_cmd_ff, since_cmd_in;
   logic        hit;

   // Checks run in a fixed order: trigger end, valve close, droplet check,
   // opening after a droplet, opening after a command, then the command itself.
   always_comb begin
      logic tick;
      tick = (req.kind == KIND_TICK);

      since_open_in  = tick ? sat_inc(since_open_ff)  : since_open_ff;
      since_laser_in = tick ? sat_inc(since_laser_ff) : since_laser_ff;
      since_drop_in  = tick ? sat_inc(since_drop_ff)  : since_drop_ff;
      since_cmd_in   = tick ? sat_inc(since_cmd_ff)   : since_cmd_ff;
      valve_in       = valve_ff;
      trig_in        = trig_ff;
      detect_in      = detect_ff;
      drop_pend_in   = drop_pend_ff;
      cmd_pend_in    = cmd_pend_ff;
      open_time_in   = open_time_ff;
      hit            = 1'b0;

      if (trig_ff && since_open_in >= cfg.trigger_width_us) begin
         trig_in = 1'b0;
      end

      // A zero open time keeps the valve open until a close command.
      if (valve_ff && open_time_ff != 32'd0 && since_open_in >= open_time_ff) begin
         valve_in  = 1'b0;
         detect_in = 1'b0;
      end

      if (req.kind == KIND_SAMPLE && detect_in && since_laser_in >= cfg.arm_delay_us &&
          {1'b0, req.sample} < cfg.dark_threshold) begin
         detect_in     = 1'b0;
         drop_pend_in  = 1'b1;
         since_drop_in = 32'd0;
         hit           = 1'b1;
      end

      if (drop_pend_in && !valve_in && since_drop_in >= cfg.open_delay_us) begin
         valve_in      = 1'b1;
         trig_in       = 1'b1;
         since_open_in = 32'd0;
         drop_pend_in  = 1'b0;
      end

      if (cmd_pend_ff && !valve_in && since_cmd_in >= cfg.open_delay_us) begin
         valve_in      = 1'b1;
         trig_in       = 1'b1;
         since_open_in = 32'd0;
         cmd_pend_in   = 1'b0;
      end

      case (req.kind)
         KIND_OPEN: begin
            open_time_in = req.duration_us;
            cmd_pend_in  = 1'b1;
            since_cmd_in = 32'd0;
         end
         KIND_CLOSE: begin
            valve_in  = 1'b0;
            detect_in = 1'b0;
         end
         KIND_DETECT: begin
            open_time_in   = req.duration_us;
            detect_in      = 1'b1;
            drop_pend_in   = 1'b0;
            since_laser_in = 32'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valve_ff       <= 1'b0;
         trig_ff        <= 1'b0;
         detect_ff      <= 1'b0;
         drop_pend_ff   <= 1'b0;
         cmd_pend_ff    <= 1'b0;
         open_time_ff   <= 32'd0;
         since_open_ff  <= 32'd0;
         since_laser_ff <= 32'd0;
         since_drop_ff  <= 32'd0;
         since_cmd_ff   <= 32'd0;
      end else if (fire) begin
         valve_ff       <= valve_in;
         trig_ff        <= trig_in;
         detect_ff      <= detect_in;
         drop_pend_ff   <= drop_pend_in;
         cmd_pend_ff    <= cmd_pend_in;
         open_time_ff   <= open_time_in;
         since_open_ff  <= since_open_in;
         since_laser_ff <= since_laser_in;
         since_drop_ff  <= since_drop_in;
         since_cmd_ff   <= since_cmd_in;
      end
   end

   assign res.valve_on     = valve_in;
   assign res.trigger_on   = trig_in;
   assign res.laser_on     = detect_in;
   assign res.waiting_open = cmd_pend_in | drop_pend_in;
   assign res.droplet_hit  = hit;

endmodule

// ===== rtl/valve_pulse_sequencer.sv =====
// An accepted request waits in the input register and moves to the response register
// once that register is free or draining. Throughput: one request per cycle while the
// response is not stalled; the timer and valve state update in one pass.
// A stalled response holds the input off only once both registers are full.
// Reset (synchronous, active high) clears all timing state and both valid flags
// and loads the configuration registers with their default values.
`include "assert_macros.svh"
module valve_pulse_sequencer import vps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [2:0]    req_kind,
   input  logic [22:0]   req_duration_ms,
   input  logic [11:0]   req_sample,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_valve_on,
   output logic          rsp_trigger_on,
   output logic          rsp_laser_on,
   output logic          rsp_waiting_open,
   output logic          rsp_droplet_hit,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata
);

   cfg_type    cfg;
   req_type    in_ff, in_in;
   logic       in_valid_ff, in_valid_in;
   result_type rsp_ff, res;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire;
   logic       req_accept;

   vps_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vps_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_ff),
      .cfg   (cfg),
      .res   (res)
   );

   // The held request moves on whenever the response register is free or draining.
   assign fire       = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = in_valid_ff & ~fire;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      in_in.kind        = req_kind;
      in_in.duration_us = ms_to_us(req_duration_ms);
      in_in.sample      = req_sample;
      in_valid_in       = req_accept | (in_valid_ff & ~fire);
      rsp_valid_in      = fire | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= in_in;
      end
      if (fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_valve_on     = rsp_ff.valve_on;
   assign rsp_trigger_on   = rsp_ff.trigger_on;
   assign rsp_laser_on     = rsp_ff.laser_on;
   assign rsp_waiting_open = rsp_ff.waiting_open;
   assign rsp_droplet_hit  = rsp_ff.droplet_hit;

   `ASSERT_SAME(a_hit_laser_off, clock, reset, rsp_valid_ff && rsp_ff.droplet_hit, !rsp_ff.laser_on)
   `ASSERT_NEXT(a_accept_held, clock, reset, req_accept, in_valid_ff)
   `ASSERT_NEXT(a_blocked_kept, clock, reset, in_valid_ff && !fire, in_valid_ff && rsp_valid_ff)

endmodule
